>>> hw/rtl/pelc_pkg.sv
package pelc_pkg;

  localparam int CoordBits = 16;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   closes_polygon;
  } edge_in_t;

  typedef struct packed {
    coord_t     seg_x0;
    coord_t     seg_y0;
    coord_t     seg_x1;
    coord_t     seg_y1;
    logic [1:0] seg_kind;
    logic       last_of_run;
  } seg_out_t;

  localparam logic [1:0] SEG_CONN  = 2'd0;
  localparam logic [1:0] SEG_EDGE  = 2'd1;
  localparam logic [1:0] SEG_CLOSE = 2'd2;

  localparam logic [1:0] CFG_X_LOW  = 2'd0;
  localparam logic [1:0] CFG_X_HIGH = 2'd1;
  localparam logic [1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [1:0] CFG_Y_HIGH = 2'd3;

  localparam logic [3:0] OC_TOP    = 4'b1000;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_LEFT   = 4'b0001;

  localparam int MaxSteps = 8;

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_DIV, DV_DONE} dv_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CODE, S_MUL, S_WAIT, S_CONN, S_EDGE, S_CLOSE
  } clip_state_t;

endpackage

>>> hw/rtl/pelc_muldiv.sv
// a*b/c, truncated toward zero; c == 0 gives 0.
// A multiply step first, then one restoring-division bit per cycle.
module pelc_muldiv #(
  parameter int W = pelc_pkg::CoordBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W:0]   op_a,
  input  logic signed [W:0]   op_b,
  input  logic signed [W:0]   op_c,
  output logic                done,
  output logic signed [W-1:0] quo
);
  import pelc_pkg::*;

  localparam int P  = 2 * W + 2;
  localparam int CW = $clog2(P + 1);

  dv_state_t      dv_state, dv_state_next;
  logic [W:0]     ma, mb, mc;
  logic           neg;
  logic [P-1:0]   prod;
  logic [P-1:0]   q;
  logic [W:0]     rem;
  logic [CW-1:0]  cnt;
  logic [W+1:0]   rem_sh;
  logic [W+1:0]   rem_sub;
  logic           fits;
  logic [P-1:0]   q_signed;

  assign rem_sh   = {rem, prod[P-1]};
  assign fits     = rem_sh >= {1'b0, mc};
  assign rem_sub  = rem_sh - {1'b0, mc};
  assign q_signed = neg ? (~q + {{(P-1){1'b0}}, 1'b1}) : q;

  always_comb begin
    dv_state_next = dv_state;
    unique case (dv_state)
      DV_IDLE: if (start) dv_state_next = DV_MUL;
      DV_MUL:  dv_state_next = DV_DIV;
      DV_DIV:  if (cnt == '0) dv_state_next = DV_DONE;
      DV_DONE: dv_state_next = DV_IDLE;
      default: dv_state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    done = (dv_state == DV_DONE);
    quo  = (mc == '0) ? '0 : q_signed[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state <= DV_IDLE;
    end else begin
      dv_state <= dv_state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (dv_state)
      DV_IDLE: begin
        ma  <= op_a[W] ? -op_a : op_a;
        mb  <= op_b[W] ? -op_b : op_b;
        mc  <= op_c[W] ? -op_c : op_c;
        neg <= op_a[W] ^ op_b[W] ^ op_c[W];
      end
      DV_MUL: begin
        prod <= P'(ma) * P'(mb);
        rem  <= '0;
        q    <= '0;
        cnt  <= CW'(P - 1);
      end
      DV_DIV: begin
        rem  <= fits ? rem_sub[W:0] : rem_sh[W:0];
        q    <= {q[P-2:0], fits};
        prod <= {prod[P-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/polygon_edge_line_clipper_top.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_item  (edge_in_t)
// out       out  out_valid / out_ready  out_item (seg_out_t)
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// One edge at a time. Each clip step is a code check, the start, one multiply,
// 2*CoordBits+2 divide bits and the done. Every step clips against a
// different window line, so at most 4 steps run; the 8-step cap never trips
// for a valid window. Each segment of an edge is handed out when out takes
// it. Sync active-high reset clears the window and the chaining state.
// in_ready is high only when idle; a stalled out holds the segment and the
// sequencer.
module polygon_edge_line_clipper_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pelc_pkg::edge_in_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pelc_pkg::seg_out_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  pelc_pkg::coord_t   cfg_data
);
  import pelc_pkg::*;

  localparam int W = CoordBits;

  clip_state_t state, state_next;

  // window
  coord_t x_low, x_high, y_low, y_high;
  // working edge
  coord_t x0, y0, x1, y1;
  logic   closing;
  logic [3:0] step;
  // chaining state
  coord_t prev_x, prev_y, first_x, first_y;
  logic   prev_end_valid, first_kept_valid;
  // clip step selection
  logic   vert, upd1;
  coord_t lim;

  logic [3:0] c0, c1, cs;
  logic       win_empty, accept_now, reject_now;
  logic signed [W:0] op_a, op_b, op_c;
  logic       dv_start, dv_done;
  coord_t     dv_quo, new_v;
  logic       in_fire, out_fire;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t xl, coord_t xh,
                                         coord_t yl, coord_t yh);
    logic [3:0] c;
    c = '0;
    if (y < yl) c = c | OC_TOP;
    if (y > yh) c = c | OC_BOTTOM;
    if (x > xh) c = c | OC_RIGHT;
    if (x < xl) c = c | OC_LEFT;
    return c;
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign c0 = outcode(x0, y0, x_low, x_high, y_low, y_high);
  assign c1 = outcode(x1, y1, x_low, x_high, y_low, y_high);
  assign cs = (c0 != '0) ? c0 : c1;
  assign win_empty  = (x_low > x_high) || (y_low > y_high);
  assign accept_now = !win_empty && (step != 4'(MaxSteps)) && ((c0 | c1) == '0);
  assign reject_now = win_empty || (step == 4'(MaxSteps)) || ((c0 & c1) != '0);

  // operands for the shared unit; base point is always endpoint 0
  always_comb begin
    if (vert) begin
      op_a = {x1[W-1], x1} - {x0[W-1], x0};
      op_b = {lim[W-1], lim} - {y0[W-1], y0};
      op_c = {y1[W-1], y1} - {y0[W-1], y0};
    end else begin
      op_a = {y1[W-1], y1} - {y0[W-1], y0};
      op_b = {lim[W-1], lim} - {x0[W-1], x0};
      op_c = {x1[W-1], x1} - {x0[W-1], x0};
    end
  end

  assign new_v = (vert ? x0 : y0) + dv_quo;

  pelc_muldiv #(.W(W)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .op_c  (op_c),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CODE;
      S_CODE: begin
        if (accept_now) state_next = prev_end_valid ? S_CONN : S_EDGE;
        else if (reject_now) state_next = (closing && first_kept_valid) ? S_CLOSE : S_IDLE;
        else state_next = S_MUL;
      end
      S_MUL:   state_next = S_WAIT;
      S_WAIT:  if (dv_done) state_next = S_CODE;
      S_CONN:  if (out_ready) state_next = S_EDGE;
      S_EDGE:  if (out_ready) state_next = closing ? S_CLOSE : S_IDLE;
      S_CLOSE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    dv_start  = (state == S_MUL);
    out_valid = 1'b0;
    out_item  = '{seg_x0: x0, seg_y0: y0, seg_x1: x1, seg_y1: y1,
                  seg_kind: SEG_EDGE, last_of_run: !closing};
    unique case (state)
      S_CONN: begin
        out_valid = 1'b1;
        out_item  = '{seg_x0: prev_x, seg_y0: prev_y, seg_x1: x0, seg_y1: y0,
                      seg_kind: SEG_CONN, last_of_run: 1'b0};
      end
      S_EDGE: out_valid = 1'b1;
      S_CLOSE: begin
        out_valid = 1'b1;
        out_item  = '{seg_x0: prev_x, seg_y0: prev_y, seg_x1: first_x, seg_y1: first_y,
                      seg_kind: SEG_CLOSE, last_of_run: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      x_low  <= '0;
      x_high <= '0;
      y_low  <= '0;
      y_high <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_X_LOW:  x_low  <= cfg_data;
          CFG_X_HIGH: x_high <= cfg_data;
          CFG_Y_LOW:  y_low  <= cfg_data;
          CFG_Y_HIGH: y_high <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      first_x <= '0;
      first_y <= '0;
      prev_end_valid   <= 1'b0;
      first_kept_valid <= 1'b0;
    end else begin
      if ((state == S_EDGE) && out_ready) begin
        prev_x <= x1;
        prev_y <= y1;
        prev_end_valid <= 1'b1;
        if (!first_kept_valid) begin
          first_x <= x0;
          first_y <= y0;
          first_kept_valid <= 1'b1;
        end
      end
      // closing item with nothing kept, or closing segment taken
      if (((state == S_CODE) && reject_now && closing && !first_kept_valid) ||
          ((state == S_CLOSE) && out_ready)) begin
        prev_x <= '0;
        prev_y <= '0;
        first_x <= '0;
        first_y <= '0;
        prev_end_valid   <= 1'b0;
        first_kept_valid <= 1'b0;
      end
    end
  end

  // working edge and clip step bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0 <= in_item.start_x;
      y0 <= in_item.start_y;
      x1 <= in_item.end_x;
      y1 <= in_item.end_y;
      closing <= in_item.closes_polygon;
      step <= '0;
    end
    if (state == S_CODE) begin
      upd1 <= (c0 == '0);
      if ((cs & OC_TOP) != '0) begin
        vert <= 1'b1;
        lim  <= y_low;
      end else if ((cs & OC_BOTTOM) != '0) begin
        vert <= 1'b1;
        lim  <= y_high;
      end else if ((cs & OC_RIGHT) != '0) begin
        vert <= 1'b0;
        lim  <= x_high;
      end else begin
        vert <= 1'b0;
        lim  <= x_low;
      end
    end
    if ((state == S_WAIT) && dv_done) begin
      step <= step + 1'b1;
      if (upd1) begin
        x1 <= vert ? new_v : lim;
        y1 <= vert ? lim : new_v;
      end else begin
        x0 <= vert ? new_v : lim;
        y0 <= vert ? lim : new_v;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready while a segment is pending");
  a_conn_needs_prev: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.seg_kind == SEG_CONN) |-> prev_end_valid)
    else $error("connector without a previous endpoint");
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_item.seg_kind == SEG_CLOSE) |=> (!prev_end_valid && !first_kept_valid))
    else $error("state not cleared after closing segment");
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_item.last_of_run) |=> in_ready)
    else $error("not idle after last segment of an item");
`endif

endmodule
